>>> rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

   // ring store size, a power of two is not required
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam int CMD_W   = 3;
   localparam int WORD_W  = 32;
   localparam int CAP_W   = 11;
   localparam int LEVEL_W = 11;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1024);
   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_REAR  = 3'd1,
      CMD_DEL_FRONT = 3'd2,
      CMD_DEL_REAR  = 3'd3,
      CMD_PEEK      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic                     empty_res;
      logic                     full_res;
      logic [LEVEL_W-1:0]       level;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic fetch;
      logic load;
   } ctl_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

   function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
      if (32'(p) == DEPTH - 1) begin
         return '0;
      end
      return p + ADDR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
      if (p == '0) begin
         return ADDR_W'(DEPTH - 1);
      end
      return p - ADDR_W'(1);
   endfunction

endpackage

>>> rtl/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdq_pkg::sts_type  sts,
   output bdq_pkg::ctl_type  ctl
);

   bdq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (req_valid) state_in = bdq_pkg::ST_EXEC;
         end
         bdq_pkg::ST_EXEC:  state_in = bdq_pkg::ST_FETCH;
         bdq_pkg::ST_FETCH: state_in = bdq_pkg::ST_LOAD;
         bdq_pkg::ST_LOAD: begin
            // hold until the output register frees up
            if (!sts.out_busy) state_in = bdq_pkg::ST_IDLE;
         end
         default: state_in = bdq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctl.latch = req_valid;
         end
         bdq_pkg::ST_EXEC:  ctl.exec  = 1'b1;
         bdq_pkg::ST_FETCH: ctl.fetch = 1'b1;
         bdq_pkg::ST_LOAD:  ctl.load  = !sts.out_busy;
         default: ;
      endcase
   end

endmodule

>>> rtl/bdq_datapath.sv
`timescale 1ns / 1ps

module bdq_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bdq_pkg::req_type               req_data,
   input  logic                           csr_valid,
   input  logic [bdq_pkg::CAP_W-1:0]      csr_data,
   input  bdq_pkg::ctl_type               ctl,
   output bdq_pkg::sts_type               sts,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bdq_pkg::rsp_type               rsp_data
);

   localparam int AW = bdq_pkg::ADDR_W;
   localparam int CW = bdq_pkg::CNT_W;
   localparam int WW = bdq_pkg::WORD_W;

   logic [WW-1:0] mem [bdq_pkg::DEPTH];

   bdq_pkg::req_type         req_ff;
   logic [AW-1:0]            front_ff, front_in;
   logic [AW-1:0]            rear_ff, rear_in;
   logic [CW-1:0]            occ_ff, occ_in;
   logic [bdq_pkg::CAP_W-1:0] cap_ff;
   logic                     ok_ff, ok_in;
   logic [WW-1:0]            rd_front_ff, rd_rear_ff;
   logic                     rsp_valid_ff;
   bdq_pkg::rsp_type         rsp_ff, rsp_in;

   logic [CW-1:0] eff_cap;
   logic          full, empty;
   logic          we;
   logic [AW-1:0] wr_addr;

   always_comb begin
      if (32'(cap_ff) > bdq_pkg::DEPTH) begin
         eff_cap = CW'(bdq_pkg::DEPTH);
      end else begin
         eff_cap = CW'(cap_ff);
      end
      full  = (occ_ff >= eff_cap);
      empty = (occ_ff == '0);
   end

   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      occ_in   = occ_ff;
      ok_in    = 1'b0;
      we       = 1'b0;
      wr_addr  = rear_ff;
      case (req_ff.cmd)
         bdq_pkg::CMD_INS_FRONT: begin
            if (!full) begin
               front_in = bdq_pkg::ptr_dec(front_ff);
               wr_addr  = front_in;
               we       = 1'b1;
               occ_in   = occ_ff + CW'(1);
               ok_in    = 1'b1;
            end
         end
         bdq_pkg::CMD_INS_REAR: begin
            if (!full) begin
               wr_addr = rear_ff;
               we      = 1'b1;
               rear_in = bdq_pkg::ptr_inc(rear_ff);
               occ_in  = occ_ff + CW'(1);
               ok_in   = 1'b1;
            end
         end
         bdq_pkg::CMD_DEL_FRONT: begin
            if (!empty) begin
               front_in = bdq_pkg::ptr_inc(front_ff);
               occ_in   = occ_ff - CW'(1);
               ok_in    = 1'b1;
            end
         end
         bdq_pkg::CMD_DEL_REAR: begin
            if (!empty) begin
               rear_in = bdq_pkg::ptr_dec(rear_ff);
               occ_in  = occ_ff - CW'(1);
               ok_in   = 1'b1;
            end
         end
         bdq_pkg::CMD_PEEK: ok_in = 1'b1;
         default: ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         occ_ff   <= '0;
         cap_ff   <= bdq_pkg::CAP_RESET;
      end else begin
         if (csr_valid) cap_ff <= csr_data;
         if (ctl.exec) begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
            occ_ff   <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) req_ff <= req_data;
      if (ctl.exec)  ok_ff  <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.exec && we) mem[wr_addr] <= req_ff.value;
   end

   // reads see the pointers as left by the exec cycle
   always_ff @(posedge clock) begin
      if (ctl.fetch) begin
         rd_front_ff <= mem[front_ff];
         rd_rear_ff  <= mem[bdq_pkg::ptr_dec(rear_ff)];
      end
   end

   always_comb begin
      rsp_in.ok          = ok_ff;
      rsp_in.front_value = empty ? bdq_pkg::EMPTY_WORD : rd_front_ff;
      rsp_in.rear_value  = empty ? bdq_pkg::EMPTY_WORD : rd_rear_ff;
      rsp_in.empty_res   = empty;
      rsp_in.full_res    = full;
      rsp_in.level       = bdq_pkg::LEVEL_W'(occ_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) rsp_ff <= rsp_in;
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

>>> rtl/bounded_deque_ring.sv
`timescale 1ns / 1ps
// a word accepted in idle goes through the exec, fetch and load states to rsp
// the controller steps each word through on its own (accept, exec, memory read,
//    output load) and takes no new word until the last is loaded; a response left
//    waiting on rsp_ready holds the load step and the next accept with it
// reset: synchronous, clears pointers, occupancy and response valid; capacity to 1024
// the ring store itself is not cleared; an empty ring shows EMPTY_WORD on rsp, not stale entries

module bounded_deque_ring (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bdq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bdq_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bdq_pkg::CAP_W-1:0] csr_data
);

   bdq_pkg::ctl_type ctl;
   bdq_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   bdq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one is in flight");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.level) <= bdq_pkg::DEPTH)
      else $error("level beyond ring depth");

   a_empty_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |->
         rsp_data.level == '0 && rsp_data.front_value == bdq_pkg::EMPTY_WORD &&
         rsp_data.rear_value == bdq_pkg::EMPTY_WORD)
      else $error("empty response inconsistent");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 !rsp_valid || !$rose(rsp_valid))
      else $error("response raised too early");

endmodule
